// File: sv/gglaw_pkg.sv
// shared types and constants for the go-to-goal velocity law
package gglaw_pkg;

   localparam int unsigned TWO_PI_Q12   = 25736;
   localparam int unsigned FOUR_PI_Q12  = 51472;
   localparam int unsigned HALF_Q12     = 2048;
   localparam int unsigned PI_Q16       = 205887;
   localparam int unsigned INV_GAIN_Q20 = 636751;
   localparam int unsigned SPEED_CAP    = 32768;
   // reciprocals for exact floor division of a 17-bit tolerance
   localparam int unsigned RECIP_10     = 209716;  // 2^21 / 10 rounded up
   localparam int unsigned RECIP_100    = 167773;  // 2^24 / 100 rounded up
   localparam int unsigned TOL_RESET    = 655;
   localparam int unsigned GAIN_RESET   = 256;

   localparam logic [1:0] CSR_GOAL_TOLERANCE = 2'd0;
   localparam logic [1:0] CSR_SPEED_GAIN     = 2'd1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ROTATE = 5'b00010,
      ST_SCALE  = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic iterate;
      logic scale;
      logic decide;
      logic finish;
      logic stop;
   } cmd_type;

   typedef struct packed {
      logic out_blocked;
   } status_type;

   // atan(2^-i) in Q16
   function automatic logic [15:0] step_angle(input logic [5:0] i);
      logic [15:0] a;
      case (i)
         6'd0:    a = 16'd51472;
         6'd1:    a = 16'd30386;
         6'd2:    a = 16'd16055;
         6'd3:    a = 16'd8150;
         6'd4:    a = 16'd4091;
         6'd5:    a = 16'd2047;
         6'd6:    a = 16'd1024;
         6'd7:    a = 16'd512;
         6'd8:    a = 16'd256;
         6'd9:    a = 16'd128;
         6'd10:   a = 16'd64;
         6'd11:   a = 16'd32;
         6'd12:   a = 16'd16;
         6'd13:   a = 16'd8;
         6'd14:   a = 16'd4;
         6'd15:   a = 16'd2;
         6'd16:   a = 16'd1;
         default: a = 16'd0;
      endcase
      return a;
   endfunction

endpackage

// File: sv/go_to_goal_velocity_law_top.sv
// top level of the go-to-goal velocity law block
// Each request carries the current pose and the goal pose and returns one
// velocity command. A control request runs the load, rotate, scale, decide
// and finish steps in order, the rotate steps on the single shared CORDIC
// vectoring unit that runs one rotation per cycle; a stop request skips to
// finish and returns a zero result. One request is in flight at a time;
// the result sits in an output register until taken, and a new request is
// accepted once the block has handed the previous result to that register.
// Configuration writes are taken on any cycle but are meant for idle periods;
// writing the tolerance clears the near-goal latch.
module go_to_goal_velocity_law_top import gglaw_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [14:0] req_yaw,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [14:0] req_target_yaw,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_linear_speed,
   output logic signed [12:0] rsp_angular_rate,
   output logic               rsp_near_goal,
   // register writes
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_wdata
);

   cmd_type                              cmd;
   status_type                           status;
   logic [$clog2(CORDIC_ITERATIONS)-1:0] iter_idx;

   // sequencer
   gglaw_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .iter_idx  (iter_idx)
   );

   // arithmetic, registers and result slot
   gglaw_dpath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .iter_idx         (iter_idx),
      .status           (status),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_yaw          (req_yaw),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_target_yaw   (req_target_yaw),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_angular_rate (rsp_angular_rate),
      .rsp_near_goal    (rsp_near_goal)
   );

endmodule

// File: sv/gglaw_ctrl.sv
// sequencer for load, cordic rotation, scaling, decision and result hand-off
module gglaw_ctrl import gglaw_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_kind,
   output logic                                 req_stall,
   input  status_type                           status,
   output cmd_type                              cmd,
   output logic [$clog2(CORDIC_ITERATIONS)-1:0] iter_idx
);

   localparam int IW = $clog2(CORDIC_ITERATIONS);
   localparam logic [IW-1:0] LAST = IW'(CORDIC_ITERATIONS - 1);

   state_type     state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          stop_ff, stop_in;
   logic          accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign iter_idx  = cnt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      stop_in  = stop_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               stop_in  = req_kind;
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = req_kind ? ST_FINISH : ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.iterate = 1'b1;
            if (cnt_ff == LAST) begin
               state_in = ST_SCALE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_blocked) begin
               cmd.finish = 1'b1;
               cmd.stop   = stop_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         stop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         stop_ff  <= stop_in;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall) else $error("request taken while idle did not start work");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST) else $error("iteration counter out of range");
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status.out_blocked) |=> state_ff == ST_FINISH)
      else $error("result dropped while output slot full");

endmodule

// File: sv/gglaw_dpath.sv
// cordic vectoring, distance scaling, heading error and speed datapath
module gglaw_dpath import gglaw_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmd_type                              cmd,
   input  logic [$clog2(CORDIC_ITERATIONS)-1:0] iter_idx,
   output status_type                           status,
   input  logic signed [31:0]                   req_pos_x,
   input  logic signed [31:0]                   req_pos_y,
   input  logic signed [14:0]                   req_yaw,
   input  logic signed [31:0]                   req_target_x,
   input  logic signed [31:0]                   req_target_y,
   input  logic signed [14:0]                   req_target_yaw,
   input  logic                                 csr_write,
   input  logic [1:0]                           csr_index,
   input  logic [16:0]                          csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [15:0]                          rsp_linear_speed,
   output logic signed [12:0]                   rsp_angular_rate,
   output logic                                 rsp_near_goal
);

   logic [16:0]        tol_ff;
   logic [12:0]        gain_ff;
   logic               latch_ff;
   logic signed [35:0] x_ff, y_ff;
   logic signed [20:0] z_ff;
   logic signed [14:0] yaw_ff, tyaw_ff;
   logic [34:0]        dist_ff;
   logic signed [16:0] bearing_ff;
   logic [47:0]        prod_ff;
   logic               turn_ff;
   logic signed [12:0] rate_ff;
   logic               rsp_valid_ff;
   logic [15:0]        speed_ff;
   logic signed [12:0] rate_out_ff;
   logic               near_out_ff;

   // load
   logic signed [35:0] dx, dy;
   assign dx = 36'(req_target_x) - 36'(req_pos_x);
   assign dy = 36'(req_target_y) - 36'(req_pos_y);

   // one cordic step
   logic signed [35:0] xs, ys;
   logic signed [20:0] ang;
   assign xs  = x_ff >>> iter_idx;
   assign ys  = y_ff >>> iter_idx;
   assign ang = $signed(21'(step_angle(6'(iter_idx))));

   // scale
   logic [34:0] xc;
   logic [54:0] mag_prod;
   logic signed [20:0] zr;
   assign xc       = x_ff[35] ? '0 : x_ff[34:0];
   assign mag_prod = 55'(xc) * 55'(INV_GAIN_Q20) + 55'(1 << 19);
   assign zr       = (z_ff + 21'sd8) >>> 4;

   // thresholds
   logic [34:0] t10p, t100p;
   logic [16:0] thr;
   logic        near;
   assign t10p  = 35'(tol_ff) * 35'(RECIP_10);
   assign t100p = 35'(tol_ff) * 35'(RECIP_100);
   assign thr   = latch_ff ? 17'(t10p >> 21) : 17'(t100p >> 24);
   assign near  = (dist_ff <= 35'(thr));

   function automatic logic signed [15:0] norm_pos(input logic signed [15:0] a);
      logic signed [15:0] r;
      r = a;
      if (r < 0) r = r + 16'sd25736;
      if (r >= 16'sd25736) r = r - 16'sd25736;
      return r;
   endfunction

   function automatic logic [21:0] mag(input logic signed [21:0] v);
      return v[21] ? 22'(-v) : 22'(v);
   endfunction

   localparam logic signed [21:0] TWO_PI  = 22'(TWO_PI_Q12);
   localparam logic signed [21:0] FOUR_PI = 22'(FOUR_PI_Q12);
   localparam logic signed [21:0] HALF    = 22'(HALF_Q12);

   logic signed [21:0] r0, r1, r2, err_near, err;
   always_comb begin
      r0 = 22'(bearing_ff) - 22'(yaw_ff);
      r1 = (mag(r0) > mag(r0 + TWO_PI)) ? r0 + TWO_PI : r0;
      if (mag(r1) > mag(r1 - TWO_PI)) begin
         r2 = r1 - TWO_PI;
      end else if (mag(r1) > mag(r1 - FOUR_PI)) begin
         r2 = r1 - FOUR_PI;
      end else begin
         r2 = r1;
      end
      err_near = 22'(norm_pos(norm_pos(16'(tyaw_ff)) - norm_pos(16'(yaw_ff))));
      err = near ? err_near : r2;
   end

   logic turn;
   assign turn = (err > HALF) || (err < -HALF);

   logic [39:0] speed_raw;
   assign speed_raw = prod_ff[47:8];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         yaw_ff  <= req_yaw;
         tyaw_ff <= req_target_yaw;
         if (dx < 0) begin
            x_ff <= -dx;
            y_ff <= -dy;
            z_ff <= (dy >= 0) ? 21'(PI_Q16) : -21'(PI_Q16);
         end else begin
            x_ff <= dx;
            y_ff <= dy;
            z_ff <= '0;
         end
      end else if (cmd.iterate) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + ang;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - ang;
         end
      end
      if (cmd.scale) begin
         dist_ff    <= 35'(mag_prod >> 20);
         bearing_ff <= zr[16:0];
      end
      if (cmd.decide) begin
         prod_ff <= 48'(dist_ff) * 48'(gain_ff);
         turn_ff <= turn;
         rate_ff <= err[21] ? -13'(HALF_Q12) : 13'(HALF_Q12);
      end
      if (cmd.finish) begin
         if (cmd.stop) begin
            speed_ff    <= '0;
            rate_out_ff <= '0;
         end else if (turn_ff) begin
            speed_ff    <= '0;
            rate_out_ff <= rate_ff;
         end else begin
            speed_ff    <= (speed_raw > 40'(SPEED_CAP)) ? 16'(SPEED_CAP) : speed_raw[15:0];
            rate_out_ff <= '0;
         end
         near_out_ff <= cmd.stop ? 1'b0 : latch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= 17'(TOL_RESET);
         gain_ff      <= 13'(GAIN_RESET);
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_GOAL_TOLERANCE) begin
            tol_ff   <= csr_wdata;
            latch_ff <= 1'b0;
         end else if (cmd.finish && cmd.stop) begin
            latch_ff <= 1'b0;
         end else if (cmd.decide && near) begin
            latch_ff <= 1'b1;
         end
         if (csr_write && csr_index == CSR_SPEED_GAIN) begin
            gain_ff <= csr_wdata[12:0];
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_blocked = rsp_valid_ff && rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_linear_speed   = speed_ff;
   assign rsp_angular_rate   = rate_out_ff;
   assign rsp_near_goal      = near_out_ff;

endmodule
